FILE: hdl/lce_pkg.sv
// Shared types and constants for the label contour extractor.
package lce_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DIM_W          = 12;
  localparam int LABEL_W        = 16;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;
  localparam int OUT_DEPTH      = 3;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } lce_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } lce_op_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } lce_cfg_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label_out;
    logic               on_contour;
    logic               end_of_frame;
  } lce_result_t;

  typedef struct packed {
    logic               emit;
    logic               last;
    logic               has_up;
    logic               has_down;
    logic               left_ok;
    logic               sel;
    logic               eof;
    logic [LABEL_W-1:0] lab;
  } lce_stage_t;

endpackage

FILE: hdl/lce_cfg.sv
// APB register file for image width and height.
module lce_cfg
  import lce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output lce_cfg_t          cfg
);

  lce_reg_t reg_sel;
  logic     wr;

  assign reg_sel = lce_reg_t'(paddr[2]);
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= WIDTH_RESET;
      cfg.image_height <= HEIGHT_RESET;
    end else if (wr) begin
      case (reg_sel)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = {{(DATA_W-DIM_W){1'b0}}, cfg.image_width};
      REG_IMAGE_HEIGHT: prdata = {{(DATA_W-DIM_W){1'b0}}, cfg.image_height};
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: hdl/lce_row_mem.sv
// One row store: two registered read ports, one write port, read-first.
module lce_row_mem
  import lce_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr0,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr1,
  output logic [LABEL_W-1:0]           rd_data0,
  output logic [LABEL_W-1:0]           rd_data1,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [LABEL_W-1:0]           wr_data
);

  logic [LABEL_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

FILE: hdl/lce_out_fifo.sv
// Small result queue between the decision stage and the output port.
module lce_out_fifo
  import lce_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  lce_result_t                    push_data,
  input  logic                           pop,
  output logic                           not_empty,
  output lce_result_t                    head,
  output logic [$clog2(OUT_DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  lce_result_t     q [OUT_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(OUT_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign not_empty = (count != '0);
  assign head      = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (!push && pop) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hdl/label_contour_extract_unit.sv
// Top level: 4-neighbour contour extraction over a label image stream.
//
//   channel  dir  handshake              payload
//   cfg      in   psel/penable/pready    paddr, pwdata, prdata
//   in       in   in_valid/in_ready      opcode, label_in
//   out      out  out_valid/out_ready    label_out, on_contour, end_of_frame
//
// One request per cycle while in_ready is high; a result passes the decision stage and then the queue.
// Each request reads both row stores once (centre/up at x, right at x+1); left is kept.
// Reset clears counters, stage valid, queue and size registers; row stores are not cleared.
// A three-entry result queue holds results while out_ready is low; in_ready
// drops once the queue plus the decision stage hold three.
module label_contour_extract_unit
  import lce_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [LABEL_W-1:0] label_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LABEL_W-1:0] label_out,
  output logic               on_contour,
  output logic               end_of_frame
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  lce_cfg_t           cfg;
  logic [WW-1:0]      w_eff;
  logic [RW-1:0]      h_eff;
  logic [XW-1:0]      column_count;
  logic [RW-1:0]      row_count;
  logic               row_select;
  logic               in_acc;
  logic               is_pix;
  logic               last;
  logic               frame_done;
  logic               go;
  logic               wr_pix;
  lce_stage_t         s1;
  logic               s1_valid;
  logic [LABEL_W-1:0] left_reg;
  logic [LABEL_W-1:0] m0_rd0, m0_rd1, m1_rd0, m1_rd1;
  logic [LABEL_W-1:0] centre, up, right;
  logic               hit;
  lce_result_t        res;
  lce_result_t        head;
  logic [CW-1:0]      fifo_count;
  logic               pop;

  lce_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_eff = RW'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(cfg.image_height);
    end
  end

  assign in_ready   = (32'(fifo_count) + 32'(s1_valid)) < OUT_DEPTH;
  assign in_acc     = in_valid && in_ready;
  assign is_pix     = (opcode == OP_PIXEL);
  assign last       = (32'(column_count) + 32'd1) >= 32'(w_eff);
  assign frame_done = 32'(row_count) >= 32'(h_eff);
  assign go         = in_acc && (is_pix ? !frame_done : frame_done);
  assign wr_pix     = go && is_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_select   <= 1'b0;
    end else if (go) begin
      if (last) begin
        column_count <= '0;
        if (is_pix) begin
          row_count  <= row_count + RW'(1);
          row_select <= ~row_select;
        end else begin
          row_count  <= '0;
        end
      end else begin
        column_count <= column_count + XW'(1);
      end
    end
  end

  // the half not selected takes the new row
  lce_row_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem0 (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr0 (column_count),
    .rd_addr1 (column_count + XW'(1)),
    .rd_data0 (m0_rd0),
    .rd_data1 (m0_rd1),
    .wr_en    (wr_pix && row_select),
    .wr_addr  (column_count),
    .wr_data  (label_in)
  );

  lce_row_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem1 (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr0 (column_count),
    .rd_addr1 (column_count + XW'(1)),
    .rd_data0 (m1_rd0),
    .rd_data1 (m1_rd1),
    .wr_en    (wr_pix && !row_select),
    .wr_addr  (column_count),
    .wr_data  (label_in)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1.emit     <= is_pix ? (row_count != '0) : 1'b1;
      s1.last     <= last;
      s1.has_up   <= 32'(row_count) >= 32'd2;
      s1.has_down <= is_pix;
      s1.left_ok  <= (column_count != '0);
      s1.sel      <= row_select;
      s1.eof      <= !is_pix && last;
      s1.lab      <= label_in;
    end
    if (s1_valid) begin
      left_reg <= centre;
    end
  end

  assign centre = s1.sel ? m1_rd0 : m0_rd0;
  assign up     = s1.sel ? m0_rd0 : m1_rd0;
  assign right  = s1.sel ? m1_rd1 : m0_rd1;

  assign hit = (centre != '0) &&
               ((s1.has_up && (up != centre)) ||
                (s1.left_ok && (left_reg != centre)) ||
                (!s1.last && (right != centre)) ||
                (s1.has_down && (s1.lab != centre)));

  assign res.label_out    = hit ? centre : '0;
  assign res.on_contour   = hit;
  assign res.end_of_frame = s1.eof;

  assign pop = out_valid && out_ready;

  lce_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid && s1.emit),
    .push_data (res),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head),
    .count     (fifo_count)
  );

  assign label_out    = head.label_out;
  assign on_contour   = head.on_contour;
  assign end_of_frame = head.end_of_frame;

endmodule

FILE: tb/sv/lce_contour_checker.sv
// Checker for the label contour extractor: predicts each result and compares it.
module lce_contour_checker
  import lce_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               opcode,
  input  logic [LABEL_W-1:0] label_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [LABEL_W-1:0] label_out,
  input  logic               on_contour,
  input  logic               end_of_frame,
  output int                 fail_count,
  output int                 pending
);

  lce_cfg_t           cfg;
  logic [LABEL_W-1:0] row_mem [0:1][0:MAX_WIDTH-1];
  int unsigned        col_q;
  int unsigned        row_q;
  bit                 sel_q;
  lce_result_t        contour_expect[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic [LABEL_W-1:0] row_at(bit half, int unsigned x);
    return row_mem[half][x % MAX_WIDTH];
  endfunction

  // centre is column x of the newest complete row
  function automatic bit centre_on_edge(int unsigned x, bit last, bit has_up, bit has_down,
                                        logic [LABEL_W-1:0] down);
    logic [LABEL_W-1:0] c;
    bit                 hit;
    c   = row_at(sel_q, x);
    hit = 1'b0;
    if (c == 0) return 1'b0;
    if (has_up && row_at(!sel_q, x) != c) hit = 1'b1;
    if (x > 0 && row_at(sel_q, x - 1) != c) hit = 1'b1;
    if (!last && row_at(sel_q, x + 1) != c) hit = 1'b1;
    if (has_down && down != c) hit = 1'b1;
    return hit;
  endfunction

  function automatic void predict_contour(lce_op_t op, logic [LABEL_W-1:0] lab);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    bit          last;
    bit          has_up;
    bit          hit;
    lce_result_t r;
    w      = eff_dim(cfg.image_width, MAX_WIDTH);
    h      = eff_dim(cfg.image_height, MAX_HEIGHT);
    x      = col_q;
    last   = (x + 1 >= w);
    has_up = (row_q >= 2);
    if (op == OP_PIXEL) begin
      if (row_q >= h) return;
      if (row_q >= 1) begin
        hit            = centre_on_edge(x, last, has_up, 1'b1, lab);
        r.label_out    = hit ? row_at(sel_q, x) : '0;
        r.on_contour   = hit;
        r.end_of_frame = 1'b0;
        contour_expect.push_back(r);
      end
      row_mem[!sel_q][x % MAX_WIDTH] = lab;
      if (last) begin
        col_q = 0;
        row_q++;
        sel_q = !sel_q;
      end else begin
        col_q++;
      end
    end else begin
      if (row_q < h) return;
      hit            = centre_on_edge(x, last, has_up, 1'b0, '0);
      r.label_out    = hit ? row_at(sel_q, x) : '0;
      r.on_contour   = hit;
      r.end_of_frame = last;
      contour_expect.push_back(r);
      if (last) begin
        col_q = 0;
        row_q = 0;
      end else begin
        col_q++;
      end
    end
  endfunction

  function automatic void check_result();
    lce_result_t exp_r;
    if (contour_expect.size() == 0) begin
      $error("unexpected result: label_out %h on_contour %b end_of_frame %b",
             label_out, on_contour, end_of_frame);
      fail_count++;
      return;
    end
    exp_r = contour_expect.pop_front();
    if (label_out !== exp_r.label_out) begin
      $error("label_out: expected %h, got %h", exp_r.label_out, label_out);
      fail_count++;
    end
    if (on_contour !== exp_r.on_contour) begin
      $error("on_contour: expected %b, got %b", exp_r.on_contour, on_contour);
      fail_count++;
    end
    if (end_of_frame !== exp_r.end_of_frame) begin
      $error("end_of_frame: expected %b, got %b", exp_r.end_of_frame, end_of_frame);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg.image_width  = WIDTH_RESET;
      cfg.image_height = HEIGHT_RESET;
      col_q            = 0;
      row_q            = 0;
      sel_q            = 1'b0;
      contour_expect.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (lce_reg_t'(paddr[ADDR_W-1:2]))
          REG_IMAGE_WIDTH:  cfg.image_width  = pwdata[DIM_W-1:0];
          REG_IMAGE_HEIGHT: cfg.image_height = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_contour(lce_op_t'(opcode), label_in);
      if (out_valid && out_ready) check_result();
    end
    pending = contour_expect.size();
  end

endmodule

FILE: tb/sv/tb_label_contour_extract_unit.sv
// Testbench top for the label contour extractor: stimulus, flow control and verdict.
module tb_label_contour_extract_unit;
  import lce_pkg::*;

  localparam int LIMIT        = 1000000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [9*LABEL_W-1:0] GRID3 = {
    16'hFFFF, 16'hFFFF, 16'h0000,
    16'hFFFF, 16'h0001, 16'h8000,
    16'h8000, 16'h8000, 16'h8000
  };

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic               opcode;
  logic [LABEL_W-1:0] label_in;
  logic               out_valid;
  logic               out_ready;
  logic [LABEL_W-1:0] label_out;
  logic               on_contour;
  logic               end_of_frame;

  int                 fail_count;
  int                 pending;
  logic               in_fire;
  int                 tx_pct;
  int                 rx_pct;
  bit                 hold_go;
  bit                 hold_done;
  logic [DIM_W-1:0]   tb_w;
  logic [DIM_W-1:0]   tb_h;
  int unsigned        st_col;
  int unsigned        st_row;
  int                 counted;
  int                 cycle_cnt;
  logic [LABEL_W-1:0] pal [0:2];
  logic [LABEL_W-1:0] last_lab;

  label_contour_extract_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .label_in(label_in),
    .out_valid(out_valid), .out_ready(out_ready), .label_out(label_out),
    .on_contour(on_contour), .end_of_frame(end_of_frame)
  );

  lce_contour_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .label_in(label_in),
    .out_valid(out_valid), .out_ready(out_ready), .label_out(label_out),
    .on_contour(on_contour), .end_of_frame(end_of_frame),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) in_fire <= in_valid && in_ready;

  function automatic int pick_gap(int pct);
    int r;
    if ($urandom_range(99) >= pct) return 0;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned dim_of(logic [DIM_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  // frame position as the block will see it; tells which requests it ignores
  function automatic bit track_req(lce_op_t op);
    bit last;
    last = (st_col + 1 >= dim_of(tb_w, DEF_MAX_WIDTH));
    if (op == OP_PIXEL) begin
      if (st_row >= dim_of(tb_h, DEF_MAX_HEIGHT)) return 1'b0;
      if (last) begin
        st_col = 0;
        st_row++;
      end else begin
        st_col++;
      end
    end else begin
      if (st_row < dim_of(tb_h, DEF_MAX_HEIGHT)) return 1'b0;
      if (last) begin
        st_col = 0;
        st_row = 0;
      end else begin
        st_col++;
      end
    end
    return 1'b1;
  endfunction

  // runs of equal labels make regions
  function automatic logic [LABEL_W-1:0] next_label();
    int                 r;
    logic [LABEL_W-1:0] lab;
    r = $urandom_range(99);
    if (r < 40) lab = last_lab;
    else if (r < 65) lab = pal[1];
    else if (r < 82) lab = pal[2];
    else if (r < 92) lab = '0;
    else lab = LABEL_W'($urandom);
    last_lab = lab;
    return lab;
  endfunction

  task automatic send_req(lce_op_t op, logic [LABEL_W-1:0] lab);
    int gap;
    gap = pick_gap(tx_pct);
    if (track_req(op)) counted++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    label_in <= lab;
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_write(lce_reg_t r, logic [DIM_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {20'($urandom), v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    quiesce();
    apb_write(REG_IMAGE_WIDTH, w);
    apb_write(REG_IMAGE_HEIGHT, h);
    tb_w = w;
    tb_h = h;
  endtask

  // mid_at: request count at which width (no larger) and height are redrawn mid-frame
  task automatic run_frame(int mid_at, int noise_pct);
    int n;
    n = 0;
    while (st_row < dim_of(tb_h, DEF_MAX_HEIGHT)) begin
      if (mid_at != 0 && n == mid_at)
        set_dims(DIM_W'($urandom_range(1, dim_of(tb_w, DEF_MAX_WIDTH))),
                 DIM_W'($urandom_range(0, dim_of(tb_h, DEF_MAX_HEIGHT) + 2)));
      if ($urandom_range(99) < noise_pct) send_req(OP_FLUSH, LABEL_W'($urandom));
      else send_req(OP_PIXEL, next_label());
      n++;
    end
    while (st_row >= dim_of(tb_h, DEF_MAX_HEIGHT)) begin
      if ($urandom_range(99) < noise_pct) send_req(OP_PIXEL, next_label());
      else send_req(OP_FLUSH, LABEL_W'($urandom));
    end
  endtask

  initial begin
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap(rx_pct);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int n;
    int mid;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    opcode    = 1'b0;
    label_in  = '0;
    tx_pct    = 20;
    rx_pct    = 20;
    hold_go   = 1'b0;
    hold_done = 1'b0;
    tb_w      = WIDTH_RESET;
    tb_h      = HEIGHT_RESET;
    st_col    = 0;
    st_row    = 0;
    counted   = 0;
    pal[0]    = '0;
    pal[1]    = LABEL_W'($urandom);
    pal[2]    = LABEL_W'($urandom);
    last_lab  = pal[1];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 3x3 with extreme labels; early flush and a stray pixel are dropped
    set_dims(3, 3);
    for (n = 0; n < 9; n++) begin
      if (n == 6) send_req(OP_FLUSH, 16'h5A5A);
      send_req(OP_PIXEL, GRID3[(8-n)*LABEL_W +: LABEL_W]);
    end
    send_req(OP_PIXEL, 16'h1234);
    repeat (3) send_req(OP_FLUSH, 16'hFFFF);

    // single row: output comes from flushes only
    set_dims(4, 1);
    send_req(OP_PIXEL, 16'd5);
    send_req(OP_PIXEL, 16'd5);
    send_req(OP_PIXEL, 16'd7);
    send_req(OP_PIXEL, 16'd0);
    repeat (4) send_req(OP_FLUSH, 16'h0000);

    // zero registers clamp to 1x1
    set_dims(0, 0);
    send_req(OP_PIXEL, 16'hABCD);
    send_req(OP_FLUSH, 16'h0000);

    // oversized registers clamp; a narrower width then ends the row early
    set_dims(12'hFFF, 12'hFFF);
    repeat (6) send_req(OP_PIXEL, next_label());
    set_dims(12'd3, 12'd1);
    run_frame(0, 0);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pal[1]   = LABEL_W'($urandom);
      pal[2]   = LABEL_W'($urandom);
      last_lab = pal[1];
      n = $urandom_range(2);
      tx_pct = (n == 0) ? 0 : (n == 1) ? 15 : 40;
      n = $urandom_range(2);
      rx_pct = (n == 0) ? 0 : (n == 1) ? 15 : 40;
      if (!hold_go && counted > RANDOM_ITEMS / 3) begin
        // long receiver hold while requests keep coming
        set_dims(16, 8);
        tx_pct  = 0;
        hold_go = 1'b1;
      end else begin
        n = $urandom_range(99);
        mid = (n < 60) ? $urandom_range(1, 6) : (n < 90) ? $urandom_range(7, 24) :
              (n < 97) ? $urandom_range(25, 80) : 0;
        n = $urandom_range(99);
        set_dims(DIM_W'(mid), DIM_W'((n < 60) ? $urandom_range(1, 5) :
                                     (n < 92) ? $urandom_range(6, 12) : 0));
      end
      mid = ($urandom_range(99) < 10) ? $urandom_range(1, 40) : 0;
      run_frame(mid, 3);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
